@@ rtl/lsda_pkg.sv @@
package lsda_pkg;

  localparam int unsigned PointerBytesDefault = 8;
  localparam int unsigned AddressBitsDefault  = 64;

  localparam logic [7:0] EncOmit  = 8'hff;
  localparam logic [7:0] EncUleb  = 8'h01;
  localparam logic [3:0] FormBad  = 4'hf;

  localparam logic [1:0] StatusDone  = 2'd0;
  localparam logic [1:0] StatusUnsup = 2'd1;
  localparam logic [1:0] StatusZeroIp = 2'd2;

  // One request handed from the front to the back.
  typedef struct packed {
    logic [7:0]  data;
    logic [63:0] addr;
    logic        first;
    logic [63:0] code_addr;
    logic [63:0] base;
  } req_t;

  // Byte count of a fixed form, 0 for LEB forms, FormBad for unknown forms.
  function automatic logic [3:0] form_size(input logic [7:0] enc, input logic [3:0] ptr_bytes);
    logic [3:0] r;
    case (enc[3:0])
      4'h0: r = ptr_bytes;
      4'h1, 4'h9: r = 4'd0;
      4'h2, 4'ha: r = 4'd2;
      4'h3, 4'hb: r = 4'd4;
      4'h4, 4'hc: r = 4'd8;
      default: r = FormBad;
    endcase
    return r;
  endfunction

  function automatic logic enc_supported(input logic [7:0] enc, input logic [3:0] ptr_bytes);
    logic ok;
    ok = !enc[7] && (enc[6:4] == 3'd0 || enc[6:4] == 3'd1)
         && (form_size(enc, ptr_bytes) != FormBad);
    return ok;
  endfunction

endpackage

@@ rtl/lsda_queue.sv @@
module lsda_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  lsda_pkg::req_t  req_i,
  output logic            valid_o,
  input  logic            stall_i,
  output lsda_pkg::req_t  req_o
);
  import lsda_pkg::*;

  req_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign stall_o = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign req_o   = mem_q[rd_q];
  assign push    = valid_i && !stall_o;
  assign pop     = valid_o && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= req_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1)) else $error("count not raised");

endmodule

@@ rtl/lsda_parser.sv @@
module lsda_parser #(
  parameter int unsigned POINTER_BYTES = lsda_pkg::PointerBytesDefault,
  parameter int unsigned ADDRESS_BITS  = lsda_pkg::AddressBitsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  lsda_pkg::req_t  req_i,
  output logic            valid_o,
  input  logic            stall_i,
  output logic            site_found_o,
  output logic            handler_present_o,
  output logic [63:0]     landing_address_o,
  output logic [1:0]      search_status_o
);
  import lsda_pkg::*;

  typedef enum logic [3:0] {
    PhIdle, PhLp, PhTtEnc, PhTtLen, PhCsEnc, PhCsLen,
    PhStart, PhLen, PhLand, PhAct, PhDone
  } phase_e;

  localparam logic [3:0] PtrB = 4'(POINTER_BYTES);
  localparam logic [63:0] Mask = (ADDRESS_BITS >= 64) ? '1 : ((64'd1 << ADDRESS_BITS) - 64'd1);

  phase_e      ph_q;
  logic [63:0] acc_q, lb_q, end_q, off_q, st_q, len_q, land_q;
  logic [6:0]  sh_q;
  logic [3:0]  left_q;
  logic [7:0]  fenc_q, senc_q;
  logic        ov_q;
  logic        fo_q, ho_q;
  logic [63:0] lo_q;
  logic [1:0]  so_q;

  logic        take;
  logic        fdone;
  logic [63:0] facc, fval, nxt, addr, ip, base, cs_end, site_hi;
  logic [6:0]  fsh;
  logic [3:0]  fleft;
  logic [7:0]  b;

  assign stall_o = ov_q && stall_i;
  assign take    = valid_i && !stall_o;
  assign valid_o = ov_q;
  assign site_found_o      = fo_q;
  assign handler_present_o = ho_q;
  assign landing_address_o = lo_q;
  assign search_status_o   = so_q;

  assign b    = req_i.data;
  assign addr = req_i.addr & Mask;
  assign nxt  = (addr + 64'd1) & Mask;
  assign ip   = req_i.code_addr & Mask;
  assign base = req_i.base & Mask;

  // One byte of the current field.
  always_comb begin
    logic sx;
    facc  = acc_q;
    fsh   = sh_q;
    fleft = left_q;
    fdone = 1'b0;
    sx    = 1'b0;
    if (fenc_q[2:0] == 3'd1) begin
      if (sh_q < 7'd64) begin
        facc = facc | ({57'd0, b[6:0]} << sh_q[5:0]);
        fsh  = sh_q + 7'd7;
      end
      fdone = !b[7];
      if (fenc_q[3] && fdone && b[6] && fsh < 7'd64) facc = facc | ('1 << fsh[5:0]);
    end else begin
      if (sh_q < 7'd64) facc = facc | ({56'd0, b} << sh_q[5:0]);
      fsh = sh_q + 7'd8;
      if (left_q != 4'd0) fleft = left_q - 4'd1;
      fdone = (fleft == 4'd0);
      if (fsh != 7'd0) sx = facc[6'(fsh - 7'd1)];
      if (fenc_q[3] && fdone && fsh < 7'd64 && sx) facc = facc | ('1 << fsh[5:0]);
    end
    fval = facc & Mask;
    if (fval != 64'd0 && fenc_q[4]) fval = (fval + nxt) & Mask;
  end

  assign cs_end  = (nxt + fval) & Mask;
  assign site_hi = (st_q + len_q) & Mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhIdle; acc_q <= '0; sh_q <= '0; left_q <= '0;
      fenc_q <= '0; senc_q <= '0; lb_q <= '0; end_q <= '0; off_q <= '0;
      st_q <= '0; len_q <= '0; land_q <= '0;
      ov_q <= 1'b0; fo_q <= 1'b0; ho_q <= 1'b0; lo_q <= '0; so_q <= StatusDone;
    end else begin
      if (ov_q && !stall_i) ov_q <= 1'b0;
      if (take) begin
        if (req_i.first) begin
          if (ip == 64'd0) begin
            ov_q <= 1'b1; fo_q <= 1'b0; ho_q <= 1'b0; lo_q <= '0;
            so_q <= StatusZeroIp; ph_q <= PhDone;
          end else begin
            off_q <= (ip - 64'd1 - base) & Mask;
            if (b == EncOmit) begin
              lb_q <= base; ph_q <= PhTtEnc;
            end else if (!enc_supported(b, PtrB)) begin
              ov_q <= 1'b1; fo_q <= 1'b0; ho_q <= 1'b0; lo_q <= '0;
              so_q <= StatusUnsup; ph_q <= PhDone;
            end else begin
              fenc_q <= b; acc_q <= '0; sh_q <= '0; left_q <= form_size(b, PtrB);
              ph_q <= PhLp;
            end
          end
        end else begin
          case (ph_q)
            PhLp, PhTtLen, PhStart, PhLen, PhLand, PhAct, PhCsLen: begin
              acc_q <= facc; sh_q <= fsh; left_q <= fleft;
              if (fdone) begin
                acc_q <= '0; sh_q <= '0; fenc_q <= senc_q;
                left_q <= form_size(senc_q, PtrB);
                case (ph_q)
                  PhLp: ph_q <= PhTtEnc;
                  PhTtLen: ph_q <= PhCsEnc;
                  PhCsLen: begin
                    end_q <= cs_end;
                    if (!(nxt < cs_end)) begin
                      ov_q <= 1'b1; fo_q <= 1'b0; ho_q <= 1'b0; lo_q <= '0;
                      so_q <= StatusDone; ph_q <= PhDone;
                    end else ph_q <= PhStart;
                  end
                  PhStart: begin st_q <= fval; ph_q <= PhLen; end
                  PhLen: begin len_q <= fval; ph_q <= PhLand; end
                  PhLand: begin
                    land_q <= fval; fenc_q <= EncUleb; left_q <= 4'd0; ph_q <= PhAct;
                  end
                  PhAct: begin
                    if (st_q <= off_q && off_q < site_hi) begin
                      ov_q <= 1'b1; fo_q <= 1'b1; so_q <= StatusDone; ph_q <= PhDone;
                      ho_q <= (land_q != 64'd0) && (fval != 64'd0);
                      lo_q <= (land_q != 64'd0) ? ((lb_q + land_q) & Mask) : '0;
                    end else if (!(nxt < end_q)) begin
                      ov_q <= 1'b1; fo_q <= 1'b0; ho_q <= 1'b0; lo_q <= '0;
                      so_q <= StatusDone; ph_q <= PhDone;
                    end else ph_q <= PhStart;
                  end
                  default: ;
                endcase
                if (ph_q == PhLp) lb_q <= fval;
              end
            end
            PhTtEnc: begin
              if (b != EncOmit) begin
                fenc_q <= EncUleb; acc_q <= '0; sh_q <= '0; left_q <= '0;
                ph_q <= PhTtLen;
              end else ph_q <= PhCsEnc;
            end
            PhCsEnc: begin
              senc_q <= b;
              if (b == EncOmit || !enc_supported(b, PtrB)) begin
                ov_q <= 1'b1; fo_q <= 1'b0; ho_q <= 1'b0; lo_q <= '0;
                so_q <= StatusUnsup; ph_q <= PhDone;
              end else begin
                fenc_q <= EncUleb; acc_q <= '0; sh_q <= '0; left_q <= '0;
                ph_q <= PhCsLen;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(landing_address_o)))
    else $error("result changed under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !site_found_o) |-> (!handler_present_o && landing_address_o == 64'd0))
    else $error("handler reported without site");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && site_found_o) |-> (search_status_o == StatusDone))
    else $error("found site with bad status");

endmodule

@@ rtl/lsda_call_site_search.sv @@
// Call-site search over an exception-handling table.
// The input channel carries one table byte per request with its address;
// table_begin_i marks the first byte and brings code_address_i and
// region_base_i. The output channel carries one result per search: found,
// handler, landing address and status.
// The block takes one byte per cycle back to back unless a result waits
// under a receiver stall. A front queue of two entries sits ahead of the
// byte decoder, which handles one byte a cycle while no result waits.
// valid_o rises once the byte that ends the search has passed through the
// queue and the decoder has registered the result. Bytes outside a search
// are dropped without a result. When the receiver stalls, the result
// register holds and the decoder takes no further bytes while the result
// waits; the queue then fills and stalls the sender.
// Reset empties the queue and returns the decoder to idle; a search
// starts only with a table_begin_i request.
module lsda_call_site_search #(
  parameter int unsigned POINTER_BYTES = lsda_pkg::PointerBytesDefault,
  parameter int unsigned ADDRESS_BITS  = lsda_pkg::AddressBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  table_byte_i,
  input  logic [63:0] byte_address_i,
  input  logic        table_begin_i,
  input  logic [63:0] code_address_i,
  input  logic [63:0] region_base_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        site_found_o,
  output logic        handler_present_o,
  output logic [63:0] landing_address_o,
  output logic [1:0]  search_status_o
);
  import lsda_pkg::*;

  req_t in_req, q_req;
  logic q_valid, q_stall;

  assign in_req = '{data: table_byte_i, addr: byte_address_i, first: table_begin_i,
                    code_addr: code_address_i, base: region_base_i};

  lsda_queue u_queue (
    .clk_i, .rst_ni, .valid_i, .stall_o, .req_i(in_req),
    .valid_o(q_valid), .stall_i(q_stall), .req_o(q_req)
  );

  lsda_parser #(.POINTER_BYTES(POINTER_BYTES), .ADDRESS_BITS(ADDRESS_BITS)) u_parser (
    .clk_i, .rst_ni, .valid_i(q_valid), .stall_o(q_stall), .req_i(q_req),
    .valid_o, .stall_i, .site_found_o, .handler_present_o,
    .landing_address_o, .search_status_o
  );

endmodule
